[sv/tccur_pkg.sv]
package tccur_pkg;

  localparam int COL_W   = 8;
  localparam int ROW_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  // wide enough for one step past the last tab stop and two row advances
  localparam int WCOL_W = COL_W + 1;
  localparam int WROW_W = ROW_W + 2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic [IDX_W-1:0] REG_COLUMNS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS     = 2'd1;
  localparam logic [IDX_W-1:0] REG_FG_COLOR = 2'd2;
  localparam logic [IDX_W-1:0] REG_BG_COLOR = 2'd3;

  localparam logic [COL_W-1:0]   COLUMNS_RST  = 8'd80;
  localparam logic [ROW_W-1:0]   ROWS_RST     = 7'd25;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST = 32'h0000_0000;

  typedef struct packed {
    logic               command;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] color;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0]   columns;
    logic [ROW_W-1:0]   rows;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] background_color;
  } cfg_t;

endpackage

[sv/tccur_step.sv]
module tccur_step #(
  parameter int TAB_STOP = 8
) (
  input  tccur_pkg::cfg_t                  cfg,
  input  logic [tccur_pkg::COL_W-1:0]      cur_col,
  input  logic [tccur_pkg::ROW_W-1:0]      cur_row,
  input  logic [tccur_pkg::CHAR_W-1:0]     char_code,
  output logic [tccur_pkg::COL_W-1:0]      col_next,
  output logic [tccur_pkg::ROW_W-1:0]      row_next,
  output tccur_pkg::result_t               res0,
  output tccur_pkg::result_t               res1,
  output logic [1:0]                       count
);

  localparam int NCOL = 1 << tccur_pkg::COL_W;

  logic [tccur_pkg::WCOL_W-1:0] tab_next [NCOL];

  // next tab stop above each column, worked out at elaboration
  for (genvar i = 0; i < NCOL; i++) begin : g_tab
    localparam int Stop = (i / TAB_STOP + 1) * TAB_STOP;
    assign tab_next[i] = tccur_pkg::WCOL_W'(Stop);
  end

  logic [tccur_pkg::WCOL_W-1:0] col_a, col_b;
  logic [tccur_pkg::WROW_W-1:0] row_a, row_b, row_c;
  logic                         draw_v, scroll_v;
  tccur_pkg::result_t           draw, scroll;

  always_comb begin
    col_a  = {1'b0, cur_col};
    row_a  = {2'b00, cur_row};
    draw_v = 1'b0;
    draw   = '0;
    case (char_code)
      tccur_pkg::CH_LF: begin
        col_a = '0;
        row_a = row_a + 1'b1;
      end
      tccur_pkg::CH_CR: begin
        col_a = '0;
      end
      tccur_pkg::CH_TAB: begin
        col_a = tab_next[cur_col];
      end
      tccur_pkg::CH_BS: begin
        if (cur_col != '0) begin
          col_a         = col_a - 1'b1;
          draw_v        = 1'b1;
          draw.command  = tccur_pkg::CMD_DRAW;
          draw.cell_col = cur_col - 1'b1;
          draw.cell_row = cur_row;
          draw.glyph    = tccur_pkg::CH_SPACE;
          draw.color    = cfg.background_color;
        end
      end
      default: begin
        if (char_code inside {[tccur_pkg::CH_SPACE:tccur_pkg::CH_DEL]}) begin
          draw_v        = 1'b1;
          draw.command  = tccur_pkg::CMD_DRAW;
          draw.cell_col = cur_col;
          draw.cell_row = cur_row;
          draw.glyph    = char_code;
          draw.color    = cfg.fg_color;
          col_a         = col_a + 1'b1;
        end
      end
    endcase

    // wrap
    col_b = col_a;
    row_b = row_a;
    if (col_a >= {1'b0, cfg.columns}) begin
      col_b = '0;
      row_b = row_a + 1'b1;
    end

    // scroll
    scroll_v       = row_b >= {2'b00, cfg.rows};
    scroll         = '0;
    scroll.command = tccur_pkg::CMD_SCROLL;
    scroll.color   = cfg.background_color;
    scroll.last    = 1'b1;
    row_c          = row_b;
    if (scroll_v && row_b != '0) begin
      row_c = row_b - 1'b1;
    end

    draw.last = !scroll_v;
    res0      = draw_v ? draw : scroll;
    res1      = scroll;
    count     = {1'b0, draw_v} + {1'b0, scroll_v};
    col_next  = col_b[tccur_pkg::COL_W-1:0];
    row_next  = row_c[tccur_pkg::ROW_W-1:0];
  end

endmodule

[sv/text_console_cursor_engine.sv]
// Text console cursor engine. Each character item yields zero, one or two
// commands (a cell draw, then a scroll), which go into a four-entry result
// queue that drives the output one command per cycle while out_ready is high.
// A new item is accepted whenever the queue has two free entries, so with
// out_ready high, items that make at most one command stream at one per cycle;
// a draw plus a scroll stalls input at the single output port. Configuration
// writes take effect at the next edge and are meant for idle periods.
module text_console_cursor_engine #(
  parameter int TAB_STOP = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tccur_pkg::IDX_W-1:0]       cfg_index,
  input  logic [tccur_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tccur_pkg::CHAR_W-1:0]      char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              command,
  output logic [tccur_pkg::COL_W-1:0]       cell_col,
  output logic [tccur_pkg::ROW_W-1:0]       cell_row,
  output logic [tccur_pkg::CHAR_W-1:0]      glyph,
  output logic [tccur_pkg::COLOR_W-1:0]     color,
  output logic                              last
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  tccur_pkg::cfg_t              cfg;
  logic [tccur_pkg::COL_W-1:0]  cursor_col, col_next;
  logic [tccur_pkg::ROW_W-1:0]  cursor_row, row_next;
  tccur_pkg::result_t           res0, res1;
  logic [1:0]                   res_count;

  tccur_pkg::result_t           queue [QDEPTH];
  logic [QPTR_W-1:0]            head, tail;
  logic [QPTR_W:0]              fill, fill_next;
  logic                         take, pop;
  logic [1:0]                   push;

  tccur_step #(
    .TAB_STOP (TAB_STOP)
  ) u_step (
    .cfg       (cfg),
    .cur_col   (cursor_col),
    .cur_row   (cursor_row),
    .char_code (char_code),
    .col_next  (col_next),
    .row_next  (row_next),
    .res0      (res0),
    .res1      (res1),
    .count     (res_count)
  );

  assign in_ready  = fill <= (QPTR_W+1)'(QDEPTH - 2);
  assign take      = in_valid && in_ready;
  assign out_valid = fill != '0;
  assign pop       = out_valid && out_ready;
  assign push      = take ? res_count : 2'd0;
  assign fill_next = fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns          <= tccur_pkg::COLUMNS_RST;
      cfg.rows             <= tccur_pkg::ROWS_RST;
      cfg.fg_color         <= tccur_pkg::FG_COLOR_RST;
      cfg.background_color <= tccur_pkg::BG_COLOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tccur_pkg::REG_COLUMNS:  cfg.columns <= cfg_data[tccur_pkg::COL_W-1:0];
        tccur_pkg::REG_ROWS:     cfg.rows <= cfg_data[tccur_pkg::ROW_W-1:0];
        tccur_pkg::REG_FG_COLOR: cfg.fg_color <= cfg_data[tccur_pkg::COLOR_W-1:0];
        tccur_pkg::REG_BG_COLOR: cfg.background_color <= cfg_data[tccur_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
    end else begin
      if (take) begin
        cursor_col <= col_next;
        cursor_row <= row_next;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      tail <= tail + QPTR_W'(push);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      queue[tail] <= res0;
    end
    if (push == 2'd2) begin
      queue[tail + 1'b1] <= res1;
    end
  end

  assign command  = queue[head].command;
  assign cell_col = queue[head].cell_col;
  assign cell_row = queue[head].cell_row;
  assign glyph    = queue[head].glyph;
  assign color    = queue[head].color;
  assign last     = queue[head].last;

endmodule
